/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the detector RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define WNHL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define WNHL_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define WNHL_ASSERT(lbl, clk, rstn, prop, msg)
`define WNHL_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* src/wnhl_pkg.sv */
// ---------------------------------------------------------------------------
// wnhl_pkg
// Shared widths, verdict codes and types of the window high/low detector.
// ---------------------------------------------------------------------------
`default_nettype none

package wnhl_pkg;

    localparam int PRICE_W    = 32;
    localparam int DATE_W     = 20;
    localparam int TOL_W      = 16;
    localparam int GROUP_SIZE = 16;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [DATE_W-1:0]  date_t;
    typedef logic [TOL_W-1:0]   tol_t;
    typedef logic [1:0]         verdict_t;

    localparam verdict_t VERDICT_NEITHER  = 2'd0;
    localparam verdict_t VERDICT_LOW      = 2'd1;
    localparam verdict_t VERDICT_HIGH     = 2'd2;
    localparam verdict_t VERDICT_NOT_FULL = 2'd3;

    // Per-cell or per-group comparison outcome.
    typedef struct packed {
        logic low;   // close + tolerance <= stored price
        logic high;  // stored price + tolerance <= close
    } cmp_flags_t;

endpackage

`default_nettype wire

/* src/wnhl_cell.sv */
// ---------------------------------------------------------------------------
// wnhl_cell
// One window slot: holds a price, compares it against the broadcast close
// and hands its price to the next slot when a word is accepted.
// ---------------------------------------------------------------------------
`default_nettype none

module wnhl_cell
    import wnhl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire price_t     price_in,
    input  wire price_t     close_price,
    input  wire tol_t       tolerance,
    output price_t          price_out,
    output cmp_flags_t      flags
);

    price_t     price_reg;
    cmp_flags_t flags_reg;
    cmp_flags_t flags_next;

    logic [PRICE_W:0] close_plus_tol;
    logic [PRICE_W:0] price_plus_tol;

    // Sums carry one extra bit so they never wrap.
    always_comb begin
        close_plus_tol   = {1'b0, close_price} + {{(PRICE_W + 1 - TOL_W){1'b0}}, tolerance};
        price_plus_tol   = {1'b0, price_reg} + {{(PRICE_W + 1 - TOL_W){1'b0}}, tolerance};
        flags_next.low   = ({1'b0, price_reg} >= close_plus_tol);
        flags_next.high  = (price_plus_tol <= {1'b0, close_price});
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            price_reg <= price_in;
            flags_reg <= flags_next;
        end
    end

    assign price_out = price_reg;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

/* src/wnhl_and_group.sv */
// ---------------------------------------------------------------------------
// wnhl_and_group
// Registered AND of the low and high flags of one group of cells.
// ---------------------------------------------------------------------------
`default_nettype none

module wnhl_and_group
    import wnhl_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             load,
    input  wire logic [WIDTH-1:0] low_vec,
    input  wire logic [WIDTH-1:0] high_vec,
    output cmp_flags_t            all_flags
);

    cmp_flags_t all_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            all_reg.low  <= &low_vec;
            all_reg.high <= &high_vec;
        end
    end

    assign all_flags = all_reg;

endmodule

`default_nettype wire

/* src/window_new_high_low_detector_unit.sv */
// ---------------------------------------------------------------------------
// window_new_high_low_detector_unit
// Sliding-window new-high / new-low detector over the last WINDOW prices.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  -------   ---------  -----------------  -------------------------------
//  s_        in         s_valid/s_ready    s_close_price, s_sample_date
//  m_        out        m_valid/m_ready    m_verdict, m_verdict_date
//  cfg_      in         cfg_wr_en          cfg_wr_data (tolerance)
//
//  One word is accepted per cycle unless a stall on m_ready has filled every
//  stage. A word goes through three registered stages: the cell row, which
//  compares the incoming close against all stored prices and shifts in the
//  same cycle, then two stages of the AND tree over the cell flags. Its valid
//  bit moves through the stage A, B and C registers; m_valid is the stage C
//  bit, and the verdict word leaves once m_ready is high. Reset clears the
//  fill counter, the stage valid bits and sets the tolerance to one; stored
//  prices need no clearing because their flags are ignored until the row is
//  full. A stall on m_ready backs up stage by stage, so input words keep
//  flowing until every stage holds a word.
`default_nettype none

module window_new_high_low_detector_unit
    import wnhl_pkg::*;
#(
    parameter int WINDOW = 250
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [PRICE_W-1:0] s_close_price,
    input  wire logic [DATE_W-1:0]  s_sample_date,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_verdict,
    output logic [DATE_W-1:0]      m_verdict_date,

    input  wire logic              cfg_wr_en,
    input  wire logic [TOL_W-1:0]  cfg_wr_data
);

`include "assert_macros.svh"

    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int NUM_GROUPS = (WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;

    // Configuration register.
    tol_t tolerance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= tol_t'(1);
        end else if (cfg_wr_en) begin
            tolerance_reg <= cfg_wr_data;
        end
    end

    // Pipeline handshake. Each stage takes a new word when it is empty or
    // when its current word moves on in the same cycle.
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;
    logic s_accept, b_load, c_load;

    assign c_ready  = !c_valid_reg || m_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_ready  = a_ready;
    assign s_accept = s_valid && s_ready;
    assign b_load   = a_valid_reg && b_ready;
    assign c_load   = b_valid_reg && c_ready;

    // Fill counter: saturates at WINDOW once the cell row holds real prices.
    logic [CNT_W-1:0] count_reg;
    logic             not_full;

    assign not_full = (count_reg < CNT_W'(WINDOW));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (s_accept && not_full) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Cell row. On every accepted word each cell compares its price with
    // the broadcast close, latches the outcome, and takes its neighbor's
    // price; the first cell takes the new close. Once full, the row thus holds
    // the most recent WINDOW prices, oldest at the far end.
    price_t     cell_price [WINDOW];
    cmp_flags_t cell_flags [WINDOW];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            price_t price_in;
            if (gi == 0) begin : g_head
                assign price_in = s_close_price;
            end else begin : g_link
                assign price_in = cell_price[gi-1];
            end

            wnhl_cell u_cell (
                .aclk        (aclk),
                .shift_en    (s_accept),
                .price_in    (price_in),
                .close_price (s_close_price),
                .tolerance   (tolerance_reg),
                .price_out   (cell_price[gi]),
                .flags       (cell_flags[gi])
            );
        end
    endgenerate

    // Stage A side data, captured with the cell flags.
    date_t a_date_reg;
    logic  a_not_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_date_reg     <= s_sample_date;
            a_not_full_reg <= not_full;
        end
    end

    // Flatten the flags, padding the last group with ones so that the
    // unused positions never veto a verdict.
    logic [PAD_W-1:0] low_flat;
    logic [PAD_W-1:0] high_flat;

    generate
        for (gi = 0; gi < PAD_W; gi++) begin : g_flat
            if (gi < WINDOW) begin : g_real
                assign low_flat[gi]  = cell_flags[gi].low;
                assign high_flat[gi] = cell_flags[gi].high;
            end else begin : g_pad
                assign low_flat[gi]  = 1'b1;
                assign high_flat[gi] = 1'b1;
            end
        end
    endgenerate

    // Stage B: one registered AND per group of cells.
    cmp_flags_t group_flags [NUM_GROUPS];
    date_t      b_date_reg;
    logic       b_not_full_reg;

    generate
        for (gi = 0; gi < NUM_GROUPS; gi++) begin : g_group
            wnhl_and_group #(
                .WIDTH (GROUP_SIZE)
            ) u_group (
                .aclk      (aclk),
                .load      (b_load),
                .low_vec   (low_flat[gi*GROUP_SIZE +: GROUP_SIZE]),
                .high_vec  (high_flat[gi*GROUP_SIZE +: GROUP_SIZE]),
                .all_flags (group_flags[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_date_reg     <= a_date_reg;
            b_not_full_reg <= a_not_full_reg;
        end
    end

    // Stage C: final AND over the groups and the verdict itself. The low
    // test wins when both hold.
    logic     all_low;
    logic     all_high;
    verdict_t verdict_next;
    verdict_t verdict_reg;
    date_t    c_date_reg;

    always_comb begin
        all_low  = 1'b1;
        all_high = 1'b1;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            all_low  = all_low  & group_flags[g].low;
            all_high = all_high & group_flags[g].high;
        end
        if (b_not_full_reg) begin
            verdict_next = VERDICT_NOT_FULL;
        end else if (all_low) begin
            verdict_next = VERDICT_LOW;
        end else if (all_high) begin
            verdict_next = VERDICT_HIGH;
        end else begin
            verdict_next = VERDICT_NEITHER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            verdict_reg <= verdict_next;
            c_date_reg  <= b_date_reg;
        end
    end

    assign m_valid        = c_valid_reg;
    assign m_verdict      = verdict_reg;
    assign m_verdict_date = c_date_reg;

    // A word taken while the row is filling comes out of stage A marked so.
    `WNHL_ASSERT(a_filling_marked, aclk, aresetn, (s_accept && not_full) |=> (a_valid_reg && a_not_full_reg), "filling word not marked not-full")
    // The fill counter never passes the window length.
    `WNHL_NEVER(a_count_bound, aclk, aresetn, (count_reg > CNT_W'(WINDOW)), "fill counter beyond window")
    // A real comparison verdict only appears once the row is full.
    `WNHL_NEVER(a_verdict_full, aclk, aresetn, (m_valid && (m_verdict != VERDICT_NOT_FULL) && not_full), "verdict issued before row full")
    // Input back-pressure only occurs with stage A occupied.
    `WNHL_NEVER(a_ready_occupancy, aclk, aresetn, (!s_ready && !a_valid_reg), "input stalled with stage A empty")

endmodule

`default_nettype wire

/* tb/window_new_high_low_detector_unit_test.sv */
// ---------------------------------------------------------------------------
// window_new_high_low_detector_unit_test
// Self-checking bench for the sliding-window new-high / new-low detector.
// ---------------------------------------------------------------------------
// Prices stream in as words on the s_ channel. A built-in predictor keeps its
// own copy of the price history and the tolerance and works out the verdict
// of every accepted word; verdicts leaving on the m_ channel are compared
// field by field, in order. The run walks through several tolerance settings
// (the extremes among them) and idling patterns on both channels. It includes
// one long output stall that backs the block up, and a window filled with one
// repeated price so that the low and high tests hold together.
// ---------------------------------------------------------------------------

module window_new_high_low_detector_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wnhl_pkg::*;

    localparam int HIST_DEPTH    = 250;     // window length of the block
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 12;      // settling margin after the last verdict
    localparam int LONG_HOLD     = 400;     // cycles of the forced output stall
    localparam int RUN_LIMIT     = 200000;  // far beyond the slowest correct run

    // One input word and one expected verdict word.
    typedef struct packed {
        price_t close;
        date_t  date;
    } quote_t;

    typedef struct packed {
        verdict_t verdict;
        date_t    date;
    } call_t;

    // Ways of choosing the next price relative to the current window contents.
    typedef enum int {
        PK_BAND,        // somewhere in the current trading band
        PK_HIGH_EDGE,   // exactly on the new-high boundary
        PK_HIGH_MISS,   // one unit short of a new high
        PK_LOW_EDGE,    // exactly on the new-low boundary
        PK_LOW_MISS,    // one unit short of a new low
        PK_ABOVE,       // clearly above every stored price
        PK_BELOW,       // clearly below every stored price
        PK_ANY          // any 32-bit value
    } price_kind_e;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic     aclk          = 1'b0;
    logic     aresetn       = 1'b0;
    logic     s_valid       = 1'b0;
    logic     s_ready;
    price_t   s_close_price = '0;
    date_t    s_sample_date = '0;
    logic     m_valid;
    logic     m_ready       = 1'b0;
    verdict_t m_verdict;
    date_t    m_verdict_date;
    logic     cfg_wr_en     = 1'b0;
    tol_t     cfg_wr_data   = '0;

    // ------------------------------------------------------------------
    // Predictor state: price history, fill level, ring slot, tolerance.
    // ------------------------------------------------------------------
    price_t      price_hist[HIST_DEPTH];
    int unsigned hist_fill = 0;
    int unsigned hist_slot = 0;
    tol_t        tolerance_now = 16'd1;   // the block comes out of reset with one

    call_t       calls_due[$];    // verdicts still to arrive, oldest first
    quote_t      quotes_q[$];     // words waiting to be offered

    // Stimulus side: the last window of generated prices and the price band.
    price_t      recent_prices[$];
    price_t      band_base = 32'd1_000_000;
    int unsigned band_span = 200_000;

    // Handshake bookkeeping and run statistics.
    int unsigned accepted_words = 0;
    int unsigned offered_words  = 0;
    int unsigned cycle_count    = 0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned fail_count = 0;
    int unsigned checked    = 0;
    int unsigned verdict_tally[4] = '{0, 0, 0, 0};
    tol_t        mid_tolerance;

    window_new_high_low_detector_unit #(
        .WINDOW(HIST_DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_close_price (s_close_price),
        .s_sample_date (s_sample_date),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_verdict_date(m_verdict_date),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Judge one close against the full history. The sums are one bit wider
    // than a price, so close plus tolerance never wraps. The high test is
    // written as stored + tolerance <= close, so a tolerance bigger than the
    // close never goes negative. The low test wins when both hold.
    function automatic verdict_t classify_close(price_t close);
        logic [32:0] close_wide;
        logic [32:0] stored_wide;
        bit          all_above;
        bit          all_below;
        close_wide = {1'b0, close};
        all_above  = 1'b1;
        all_below  = 1'b1;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            stored_wide = {1'b0, price_hist[i]};
            if (stored_wide < close_wide + tolerance_now) begin
                all_above = 1'b0;
            end
            if (stored_wide + tolerance_now > close_wide) begin
                all_below = 1'b0;
            end
        end
        if (all_above) begin
            return VERDICT_LOW;
        end
        if (all_below) begin
            return VERDICT_HIGH;
        end
        return VERDICT_NEITHER;
    endfunction

    // Pick a price of the given kind against the prices generated so far.
    // Boundary kinds only make sense once a full window lies behind them, and
    // any target outside 32 bits falls back to the band.
    function automatic price_t pick_price(price_kind_e kind);
        logic [32:0] top;
        logic [32:0] bottom;
        logic [32:0] want;
        top    = '0;
        bottom = 33'h0_FFFF_FFFF;
        foreach (recent_prices[i]) begin
            if (recent_prices[i] > top) begin
                top = {1'b0, recent_prices[i]};
            end
            if (recent_prices[i] < bottom) begin
                bottom = {1'b0, recent_prices[i]};
            end
        end
        if (recent_prices.size() < HIST_DEPTH && kind != PK_ANY) begin
            kind = PK_BAND;
        end
        case (kind)
            PK_HIGH_EDGE: want = top + tolerance_now;
            PK_HIGH_MISS: want = top + tolerance_now - 33'd1;
            PK_ABOVE:     want = top + tolerance_now + $urandom_range(1, 5000);
            PK_LOW_EDGE:  want = bottom - tolerance_now;
            PK_LOW_MISS:  want = bottom - tolerance_now + 33'd1;
            PK_BELOW:     want = bottom - tolerance_now - $urandom_range(1, 5000);
            PK_ANY:       want = {1'b0, $urandom()};
            default:      want = 33'h1_0000_0000;
        endcase
        // Subtractions that went below zero wrap past 32 bits and land here too.
        if (want > 33'h0_FFFF_FFFF) begin
            want = {1'b0, band_base} + 33'($urandom_range(0, band_span));
        end
        return want[31:0];
    endfunction

    task automatic queue_quote(price_t close, date_t date);
        quote_t q;
        q.close = close;
        q.date  = date;
        quotes_q = {quotes_q, q};
        recent_prices = {recent_prices, close};
        if (recent_prices.size() > HIST_DEPTH) begin
            void'(recent_prices.pop_front());
        end
    endtask

    // Mostly well-formed market movement: band prices and prices placed on or
    // next to the high and low boundaries, with some wild values mixed in.
    task automatic queue_market(int unsigned count);
        int unsigned roll;
        price_kind_e kind;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                kind = PK_BAND;
            end else if (roll < 50) begin
                kind = PK_HIGH_EDGE;
            end else if (roll < 58) begin
                kind = PK_HIGH_MISS;
            end else if (roll < 68) begin
                kind = PK_LOW_EDGE;
            end else if (roll < 76) begin
                kind = PK_LOW_MISS;
            end else if (roll < 86) begin
                kind = PK_ABOVE;
            end else if (roll < 96) begin
                kind = PK_BELOW;
            end else begin
                kind = PK_ANY;
            end
            queue_quote(pick_price(kind), date_t'($urandom_range(0, 32'hF_FFFF)));
        end
    endtask

    // Hold back the next phase until the block has delivered every verdict,
    // then wait out the settling margin to be sure nothing is still in flight.
    task automatic wait_for_quiet();
        while (quotes_q.size() != 0 || offered_words != accepted_words ||
               calls_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tolerance(tol_t value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tolerance_now = value;
    endtask

    task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // Cycle counter and run limit.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                     $time, cycle_count, calls_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input driver. A new word is shown only once the previous one has been
    // taken, so valid and the payload stay put across any backpressure.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : sender
        quote_t q;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (accepted_words == offered_words) begin
            if (quotes_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                q = quotes_q.pop_front();
                s_valid       <= 1'b1;
                s_close_price <= q.close;
                s_sample_date <= q.date;
                offered_words++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready. Random stalls per phase, plus a long hold on request that
    // this process counts down itself.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        int unsigned hold_served;
        int unsigned hold_left;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            hold_served = 0;
            hold_left   = 0;
        end else begin
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left   = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and predictor. The outgoing word is checked before the incoming
    // one is predicted; with the stage registers in between they never meet.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        call_t    due;
        call_t    made;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (calls_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: verdict word with none expected, verdict %0d date %0d",
                             $time, m_verdict, m_verdict_date);
                end else begin
                    due = calls_due.pop_front();
                    checked++;
                    verdict_tally[m_verdict]++;
                    if (m_verdict !== due.verdict) begin
                        fail_count++;
                        $display("%0t: verdict mismatch, expected %0d, actual %0d",
                                 $time, due.verdict, m_verdict);
                    end
                    if (m_verdict_date !== due.date) begin
                        fail_count++;
                        $display("%0t: verdict_date mismatch, expected %0d, actual %0d",
                                 $time, due.date, m_verdict_date);
                    end
                end
            end
            if (s_valid && s_ready) begin
                accepted_words++;
                made.date    = s_sample_date;
                made.verdict = (hist_fill < HIST_DEPTH) ? VERDICT_NOT_FULL
                                                        : classify_close(s_close_price);
                calls_due = {calls_due, made};
                // The price enters the ring after it has been judged.
                price_hist[hist_slot] = s_close_price;
                hist_slot = (hist_slot == HIST_DEPTH - 1) ? 0 : hist_slot + 1;
                if (hist_fill < HIST_DEPTH) begin
                    hist_fill++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, phase by phase.
    // ------------------------------------------------------------------
    initial begin
        price_t flat;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Phase one: reset tolerance, no idling. Fill the window (every word
        // reports not full, the first and second carry the date extremes),
        // then hit each boundary directly, then both price extremes, then market moves.
        set_idling(0, 0);
        for (int i = 0; i < HIST_DEPTH; i++) begin
            queue_quote(pick_price(PK_BAND),
                        (i == 0) ? date_t'(0) :
                        (i == 1) ? date_t'(20'hF_FFFF) :
                                   date_t'($urandom_range(0, 32'hF_FFFF)));
        end
        queue_quote(pick_price(PK_HIGH_EDGE), date_t'(17));
        queue_quote(pick_price(PK_HIGH_MISS), date_t'(18));
        queue_quote(pick_price(PK_LOW_EDGE), date_t'(19));
        queue_quote(pick_price(PK_LOW_MISS), date_t'(20));
        queue_quote(pick_price(PK_ABOVE), date_t'(21));
        queue_quote(pick_price(PK_BELOW), date_t'(22));
        queue_quote(32'd0, date_t'(0));
        queue_quote(32'hFFFF_FFFF, date_t'(20'hF_FFFF));
        queue_market(110);
        wait_for_quiet();

        // Phase two: no tolerance at all, sender idle most of the time.
        write_tolerance(16'd0);
        set_idling(60, 0);
        queue_market(300);
        wait_for_quiet();

        // Phase three: largest tolerance over prices near zero, so the close
        // is often smaller than the tolerance. The receiver stalls often and
        // once holds off long enough for the block to fill and refuse input.
        write_tolerance(16'hFFFF);
        set_idling(0, 60);
        band_base = 32'd0;
        band_span = 150_000;
        hold_asked++;
        queue_market(250);
        wait_for_quiet();

        // Phase four: a random tolerance, light idling on both sides.
        mid_tolerance = tol_t'($urandom_range(2, 16'hFFFE));
        write_tolerance(mid_tolerance);
        set_idling(10, 10);
        band_base = price_t'($urandom_range(100_000, 32'h4000_0000));
        band_span = 1_000_000;
        queue_market(300);
        wait_for_quiet();

        // Phase five: zero tolerance over a flat window. The repeated price
        // passes both tests and must come out as a new low; then one tick up,
        // one tick down and the flat price again.
        write_tolerance(16'd0);
        set_idling(0, 0);
        flat = price_t'($urandom_range(1000, 32'h7FFF_FFFF));
        for (int i = 0; i < HIST_DEPTH + 5; i++) begin
            queue_quote(flat, date_t'($urandom_range(0, 32'hF_FFFF)));
        end
        queue_quote(flat + 32'd1, date_t'($urandom_range(0, 32'hF_FFFF)));
        queue_quote(flat - 32'd1, date_t'($urandom_range(0, 32'hF_FFFF)));
        queue_quote(flat, date_t'($urandom_range(0, 32'hF_FFFF)));
        wait_for_quiet();

        $display("Checked %0d verdict words: %0d new lows, %0d new highs, %0d neither, %0d filling.",
                 checked, verdict_tally[VERDICT_LOW], verdict_tally[VERDICT_HIGH],
                 verdict_tally[VERDICT_NEITHER], verdict_tally[VERDICT_NOT_FULL]);
        $display("Tolerances 1, 0, 65535, %0d and 0 were used; one %0d-cycle output hold.",
                 mid_tolerance, LONG_HOLD);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/wnhl_pkg.sv
src/wnhl_cell.sv
src/wnhl_and_group.sv
src/window_new_high_low_detector_unit.sv
tb/window_new_high_low_detector_unit_test.sv
